// File: rtl/tsc_pkg.sv
`default_nettype none
package tsc_pkg;

  localparam int FRAC_BITS     = 24;
  localparam int CORDIC_STAGES = 24;

  localparam logic signed [63:0] ONE_S     = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] EPOCH_S   = 64'sd630763200 * ONE_S;
  localparam logic signed [63:0] TDT_DELTA = (64'sd51184 * ONE_S + 64'sd500) / 64'sd1000;
  localparam logic signed [63:0] TAI_DELTA = 64'sd19 * ONE_S;
  localparam logic signed [63:0] OFF_TDT   = TDT_DELTA - EPOCH_S;
  localparam logic signed [63:0] OFF_TAI   = TAI_DELTA - EPOCH_S;

  localparam logic [63:0] M0_TURN = 64'd18319944996931551616;
  localparam logic [63:0] M1_TURN = 64'd9806729240728552000;
  localparam logic signed [24:0] EB_TURN = 25'sd11422376;
  localparam logic signed [31:0] KK_Q40  = 32'sd1821890767;

  localparam logic signed [33:0] CORDIC_X0 = 34'sh026DD3B6A;
  localparam logic signed [33:0] QUARTER   = 34'sd1 <<< 30;
  localparam logic signed [33:0] HALF      = 34'sd1 <<< 31;

  localparam int PROD_LSB = FRAC_BITS + 24;
  localparam int KK_SHIFT = 70 - FRAC_BITS;

  typedef enum logic [2:0] {
    CMD_GPS_TDT,
    CMD_TDT_GPS,
    CMD_GPS_TAI,
    CMD_TAI_GPS,
    CMD_TDT_TDB,
    CMD_TDB_TDT,
    CMD_GPS_TDB,
    CMD_TDB_GPS
  } cmd_e;

  // Item context that travels alongside a correction pipeline.
  typedef struct packed {
    cmd_e               cmd;
    logic signed [63:0] t1;
    logic               sat;
  } side_t;

  typedef struct packed {
    logic               sat;
    logic signed [63:0] v;
  } sum_t;

  function automatic sum_t sat_add(input logic signed [63:0] a, input logic signed [63:0] b);
    sum_t r;
    r.v   = a + b;
    r.sat = 1'b0;
    if (!a[63] && !b[63] && r.v[63]) begin
      r.sat = 1'b1;
      r.v   = {1'b0, {63{1'b1}}};
    end else if (a[63] && b[63] && !r.v[63]) begin
      r.sat = 1'b1;
      r.v   = {1'b1, {63{1'b0}}};
    end
    return r;
  endfunction

  // Arctangent of 2^-i in Q32 turns, truncated.
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051D;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2E;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2F9;
      5'd15: r = 32'h0000517C;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A2F;
      5'd19: r = 32'h00000517;
      5'd20: r = 32'h0000028B;
      5'd21: r = 32'h00000145;
      5'd22: r = 32'h000000A2;
      5'd23: r = 32'h00000051;
      5'd24: r = 32'h00000028;
      5'd25: r = 32'h00000014;
      5'd26: r = 32'h0000000A;
      5'd27: r = 32'h00000005;
      5'd28: r = 32'h00000002;
      5'd29: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/tsc_if.sv
`default_nettype none
interface tsc_in_if;
  logic               valid;
  logic               ready;
  tsc_pkg::cmd_e      cmd;
  logic signed [63:0] time_in;
  modport source (output valid, cmd, time_in, input ready);
  modport sink   (input valid, cmd, time_in, output ready);
endinterface

interface tsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [63:0] time_out;
  logic               saturated;
  modport source (output valid, time_out, saturated, input ready);
  modport sink   (input valid, time_out, saturated, output ready);
endinterface
`default_nettype wire

// File: rtl/tsc_cordic.sv
`default_nettype none
module tsc_cordic (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [31:0]         phase_i,
  input  logic [31:0]         aux_i,
  input  tsc_pkg::side_t      side_i,
  output logic                valid_o,
  output logic signed [33:0]  sin_o,
  output logic [31:0]         aux_o,
  output tsc_pkg::side_t      side_o
);

  localparam int N = tsc_pkg::CORDIC_STAGES;

  logic [N:0]         v_q;
  logic signed [33:0] x_q [N+1];
  logic signed [33:0] y_q [N+1];
  logic signed [33:0] z_q [N+1];
  logic [31:0]        aux_q [N+1];
  tsc_pkg::side_t     side_q [N+1];

  logic signed [33:0] z_fold;

  // Map the phase to a signed angle, then mirror it into the right half plane.
  always_comb begin
    z_fold = signed'({{2{phase_i[31]}}, phase_i});
    if (z_fold > tsc_pkg::QUARTER) begin
      z_fold = tsc_pkg::HALF - z_fold;
    end else if (z_fold < -tsc_pkg::QUARTER) begin
      z_fold = -tsc_pkg::HALF - z_fold;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q[0]    <= tsc_pkg::CORDIC_X0;
      y_q[0]    <= '0;
      z_q[0]    <= z_fold;
      aux_q[0]  <= aux_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    logic signed [33:0] dx, dy, at;
    assign dx = y_q[i] >>> i;
    assign dy = x_q[i] >>> i;
    assign at = signed'({2'b00, tsc_pkg::atan_turn(5'(i))});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (en_i) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (!z_q[i][33]) begin
          x_q[i+1] <= x_q[i] - dx;
          y_q[i+1] <= y_q[i] + dy;
          z_q[i+1] <= z_q[i] - at;
        end else begin
          x_q[i+1] <= x_q[i] + dx;
          y_q[i+1] <= y_q[i] - dy;
          z_q[i+1] <= z_q[i] + at;
        end
        aux_q[i+1]  <= aux_q[i];
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = v_q[N];
  assign sin_o   = y_q[N];
  assign aux_o   = aux_q[N];
  assign side_o  = side_q[N];

endmodule
`default_nettype wire

// File: rtl/tsc_corr.sv
`default_nettype none
module tsc_corr (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [63:0] t_i,
  input  tsc_pkg::side_t     side_i,
  output logic               valid_o,
  output logic signed [63:0] corr_o,
  output tsc_pkg::side_t     side_o
);

  // Product stage: four 32x32 partial products of t * M1.
  logic           p_v_q;
  logic [63:0]    p00_q, p01_q, p10_q, p11_q;
  logic           neg_q;
  tsc_pkg::side_t p_side_q;

  // Sum stage: the slice of the signed 128-bit product that forms the turn fraction.
  logic           q_v_q;
  logic [63:0]    prod_q;
  tsc_pkg::side_t q_side_q;
  logic [127:0]   full;

  // Mean anomaly stage.
  logic           r_v_q;
  logic [31:0]    m32_q;
  tsc_pkg::side_t r_side_q;
  logic [63:0]    m64;

  logic               c1_v;
  logic signed [33:0] c1_sin;
  logic [31:0]        c1_aux;
  tsc_pkg::side_t     c1_side;

  logic               d_v_q;
  logic signed [58:0] deb_q;
  logic [31:0]        d_m32_q;
  tsc_pkg::side_t     d_side_q;
  logic signed [58:0] deb_sh;

  logic               e_v_q;
  logic [31:0]        e32_q;
  tsc_pkg::side_t     e_side_q;

  logic               c2_v;
  logic signed [33:0] c2_sin;
  tsc_pkg::side_t     c2_side;

  logic               k_v_q;
  logic signed [65:0] kk_q;
  tsc_pkg::side_t     k_side_q;
  logic signed [65:0] kk_sh;

  logic               o_v_q;
  logic signed [63:0] corr_q;
  tsc_pkg::side_t     o_side_q;

  always_comb begin
    full = {64'd0, p00_q} + ({64'd0, p01_q} << 32) + ({64'd0, p10_q} << 32)
           + {p11_q, 64'd0};
    if (neg_q) begin
      full = full - {tsc_pkg::M1_TURN, 64'd0};
    end
  end

  assign m64    = tsc_pkg::M0_TURN + prod_q;
  assign deb_sh = deb_q >>> 30;
  assign kk_sh  = kk_q >>> tsc_pkg::KK_SHIFT;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
      q_v_q <= 1'b0;
      r_v_q <= 1'b0;
      d_v_q <= 1'b0;
      e_v_q <= 1'b0;
      k_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else if (en_i) begin
      p_v_q <= valid_i;
      q_v_q <= p_v_q;
      r_v_q <= q_v_q;
      d_v_q <= c1_v;
      e_v_q <= d_v_q;
      k_v_q <= c2_v;
      o_v_q <= k_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p00_q    <= 64'(t_i[31:0])  * 64'(tsc_pkg::M1_TURN[31:0]);
      p01_q    <= 64'(t_i[31:0])  * 64'(tsc_pkg::M1_TURN[63:32]);
      p10_q    <= 64'(t_i[63:32]) * 64'(tsc_pkg::M1_TURN[31:0]);
      p11_q    <= 64'(t_i[63:32]) * 64'(tsc_pkg::M1_TURN[63:32]);
      neg_q    <= t_i[63];
      p_side_q <= side_i;

      prod_q   <= full[tsc_pkg::PROD_LSB +: 64];
      q_side_q <= p_side_q;

      m32_q    <= m64[63:32];
      r_side_q <= q_side_q;

      deb_q    <= 59'(c1_sin * tsc_pkg::EB_TURN);
      d_m32_q  <= c1_aux;
      d_side_q <= c1_side;

      e32_q    <= d_m32_q + deb_sh[31:0];
      e_side_q <= d_side_q;

      kk_q     <= 66'(c2_sin * tsc_pkg::KK_Q40);
      k_side_q <= c2_side;

      corr_q   <= kk_sh[63:0];
      o_side_q <= k_side_q;
    end
  end

  tsc_cordic u_sin_m (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (r_v_q),
    .phase_i (m32_q),
    .aux_i   (m32_q),
    .side_i  (r_side_q),
    .valid_o (c1_v),
    .sin_o   (c1_sin),
    .aux_o   (c1_aux),
    .side_o  (c1_side)
  );

  tsc_cordic u_sin_e (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (e_v_q),
    .phase_i (e32_q),
    .aux_i   (e32_q),
    .side_i  (e_side_q),
    .valid_o (c2_v),
    .sin_o   (c2_sin),
    .aux_o   (),
    .side_o  (c2_side)
  );

  assign valid_o = o_v_q;
  assign corr_o  = corr_q;
  assign side_o  = o_side_q;

endmodule
`default_nettype wire

// File: rtl/time_scale_converter.sv
// Time scale converter: GPS, TAI, TDT and TDB timestamps, signed seconds with
// 24 fraction bits.
// Input channel in_i carries cmd and time_in; output channel out_o carries
// time_out and saturated. Both use valid/ready; an item moves when both are high.
// The block is one pipeline of 117 register stages: an entry stage with the
// fixed offsets, two TDB correction units (each 57 stages: a split 64x64
// constant multiply, two 24-stage CORDIC sine pipelines and two small
// multiplies), a stage between them and the output register.
// Every item runs through all of these stages to out_o.valid, whatever its cmd,
// and one item is accepted per cycle while the output is not stalled.
// When the receiver holds out_o.ready low with a result waiting, the whole
// pipeline freezes and in_i.ready drops in the same cycle; nothing is lost.
// Reset clears all valid bits; the block carries no other state.
`default_nettype none
module time_scale_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  tsc_in_if.sink      in_i,
  tsc_out_if.source   out_o
);

  logic en;

  logic           s0_v_q;
  tsc_pkg::side_t s0_side_q;
  tsc_pkg::side_t s0_side_d;
  tsc_pkg::sum_t  s0_sum;

  logic               c1_v;
  logic signed [63:0] c1_corr;
  tsc_pkg::side_t     c1_side;

  logic               s1_v_q;
  logic signed [63:0] s1_t_q;
  logic signed [63:0] s1_t_d;
  tsc_pkg::side_t     s1_side_q;
  tsc_pkg::side_t     s1_side_d;
  tsc_pkg::sum_t      s1_sum;

  logic               c2_v;
  logic signed [63:0] c2_corr;
  tsc_pkg::side_t     c2_side;

  logic               out_v_q;
  logic signed [63:0] out_time_q;
  logic               out_sat_q;
  tsc_pkg::sum_t      out_sum;
  logic signed [63:0] out_time_d;
  logic               out_sat_d;

  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = en;

  // Entry stage: plain offset modes finish here; GPS to TDB moves to TDT first.
  always_comb begin
    s0_side_d.cmd = in_i.cmd;
    s0_side_d.t1  = in_i.time_in;
    s0_side_d.sat = 1'b0;
    s0_sum        = '0;
    case (in_i.cmd)
      tsc_pkg::CMD_GPS_TDT: s0_sum = tsc_pkg::sat_add(in_i.time_in, tsc_pkg::OFF_TDT);
      tsc_pkg::CMD_TDT_GPS: s0_sum = tsc_pkg::sat_add(in_i.time_in, -tsc_pkg::OFF_TDT);
      tsc_pkg::CMD_GPS_TAI: s0_sum = tsc_pkg::sat_add(in_i.time_in, tsc_pkg::OFF_TAI);
      tsc_pkg::CMD_TAI_GPS: s0_sum = tsc_pkg::sat_add(in_i.time_in, -tsc_pkg::OFF_TAI);
      tsc_pkg::CMD_GPS_TDB: s0_sum = tsc_pkg::sat_add(in_i.time_in, tsc_pkg::OFF_TDT);
      default:              s0_sum = '{sat: 1'b0, v: in_i.time_in};
    endcase
    s0_side_d.t1  = s0_sum.v;
    s0_side_d.sat = s0_sum.sat;
  end

  // Middle stage: the first correction gives the TDB estimate for the
  // two-pass modes and the final TDT for the reverse modes.
  always_comb begin
    s1_side_d = c1_side;
    s1_t_d    = c1_side.t1;
    s1_sum    = '0;
    case (c1_side.cmd)
      tsc_pkg::CMD_TDT_TDB, tsc_pkg::CMD_GPS_TDB: begin
        s1_sum        = tsc_pkg::sat_add(c1_side.t1, c1_corr);
        s1_t_d        = s1_sum.v;
        s1_side_d.sat = c1_side.sat | s1_sum.sat;
      end
      tsc_pkg::CMD_TDB_TDT, tsc_pkg::CMD_TDB_GPS: begin
        s1_sum        = tsc_pkg::sat_add(c1_side.t1, -c1_corr);
        s1_side_d.t1  = s1_sum.v;
        s1_side_d.sat = c1_side.sat | s1_sum.sat;
      end
      default: begin
        s1_sum = '0;
      end
    endcase
  end

  always_comb begin
    out_sum    = '0;
    out_time_d = c2_side.t1;
    out_sat_d  = c2_side.sat;
    case (c2_side.cmd)
      tsc_pkg::CMD_TDT_TDB, tsc_pkg::CMD_GPS_TDB: begin
        out_sum    = tsc_pkg::sat_add(c2_side.t1, c2_corr);
        out_time_d = out_sum.v;
        out_sat_d  = c2_side.sat | out_sum.sat;
      end
      tsc_pkg::CMD_TDB_GPS: begin
        out_sum    = tsc_pkg::sat_add(c2_side.t1, -tsc_pkg::OFF_TDT);
        out_time_d = out_sum.v;
        out_sat_d  = c2_side.sat | out_sum.sat;
      end
      default: begin
        out_sum = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q  <= 1'b0;
      s1_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s0_v_q  <= in_i.valid;
      s1_v_q  <= c1_v;
      out_v_q <= c2_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_side_q  <= s0_side_d;
      s1_side_q  <= s1_side_d;
      s1_t_q     <= s1_t_d;
      out_time_q <= out_time_d;
      out_sat_q  <= out_sat_d;
    end
  end

  tsc_corr u_corr_a (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s0_v_q),
    .t_i     (s0_side_q.t1),
    .side_i  (s0_side_q),
    .valid_o (c1_v),
    .corr_o  (c1_corr),
    .side_o  (c1_side)
  );

  tsc_corr u_corr_b (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s1_v_q),
    .t_i     (s1_t_q),
    .side_i  (s1_side_q),
    .valid_o (c2_v),
    .corr_o  (c2_corr),
    .side_o  (c2_side)
  );

  assign out_o.valid     = out_v_q;
  assign out_o.time_out  = out_time_q;
  assign out_o.saturated = out_sat_q;

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_o.ready) |-> !in_i.ready)
    else $error("input accepted while the output is stalled");

  a_frozen_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> ($stable(s0_v_q) && $stable(s1_v_q)))
    else $error("pipeline valid bits moved during a stall");

  a_empty_after_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (!out_v_q && !s0_v_q && !s1_v_q))
    else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

// File: tb/time_scale_converter_tb.sv
`timescale 1ns / 100ps
module time_scale_converter_tb;
  import tsc_pkg::*;

  localparam int LONG_HOLD    = 400;
  localparam int HOLD_AT      = 200;
  localparam int PAUSE_AT     = 700;
  localparam int TIMEOUT_CYC  = 300000;
  localparam int DRAIN_CYC    = 160;
  localparam int RANDOM_ITEMS = 1330;

  localparam longint MAX_T = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint MIN_T = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    cmd_e               cmd;
    logic signed [63:0] t;
  } stamp_t;

  typedef struct packed {
    logic signed [63:0] t;
    logic               sat;
  } conv_t;

  localparam logic [31:0] ATAN_Q32 [32] = '{
    32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
    32'h00000000, 32'h00000000
  };

  logic clk;
  logic rst_n;
  tsc_in_if  in_ch ();
  tsc_out_if out_ch ();

  time_scale_converter dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  stamp_t pending_stamps[$];
  conv_t  expected_convs[$];
  int     accepted;
  int     hold_left;
  int     cycles;
  bit     in_taken;
  bit     hold_done;
  bit     pausing;
  bit     pause_done;
  bit     failed;

  function automatic longint clip_add(longint a, longint b, inout logic flag);
    longint s;
    s = a + b;
    if (a >= 0 && b >= 0 && s < 0) begin
      flag = 1'b1;
      return MAX_T;
    end
    if (a < 0 && b < 0 && s >= 0) begin
      flag = 1'b1;
      return MIN_T;
    end
    return s;
  endfunction

  function automatic longint sine_q30(logic [31:0] phase);
    longint z, x, y, dx, dy;
    z = longint'({32'd0, phase});
    x = longint'(CORDIC_X0);
    y = 0;
    if (z >= longint'(HALF)) z -= 2 * longint'(HALF);
    if (z > longint'(QUARTER)) z = longint'(HALF) - z;
    else if (z < -longint'(QUARTER)) z = -longint'(HALF) - z;
    for (int i = 0; i < CORDIC_STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'({32'd0, ATAN_Q32[i]});
      end else begin
        x += dx; y -= dy; z += longint'({32'd0, ATAN_Q32[i]});
      end
    end
    return y;
  endfunction

  // Periodic TDB minus TDT term at time t.
  function automatic longint tdb_offset(longint t);
    logic signed [127:0] p;
    logic [63:0] m64;
    logic [31:0] m32, e32;
    longint s, d;
    p = $signed({{64{t[63]}}, t}) * $signed({64'd0, M1_TURN});
    m64 = M0_TURN + p[PROD_LSB +: 64];
    m32 = m64[63:32];
    s = sine_q30(m32);
    d = (s * longint'(EB_TURN)) >>> 30;
    e32 = m32 + d[31:0];
    s = sine_q30(e32);
    return (s * longint'(KK_Q40)) >>> KK_SHIFT;
  endfunction

  function automatic longint to_tdb(longint t, inout logic flag);
    longint est;
    est = clip_add(t, tdb_offset(t), flag);
    return clip_add(t, tdb_offset(est), flag);
  endfunction

  function automatic conv_t convert(stamp_t s);
    conv_t r;
    logic f;
    longint t;
    f = 1'b0;
    case (s.cmd)
      CMD_GPS_TDT: t = clip_add(s.t, OFF_TDT, f);
      CMD_TDT_GPS: t = clip_add(s.t, -OFF_TDT, f);
      CMD_GPS_TAI: t = clip_add(s.t, OFF_TAI, f);
      CMD_TAI_GPS: t = clip_add(s.t, -OFF_TAI, f);
      CMD_TDT_TDB: t = to_tdb(s.t, f);
      CMD_TDB_TDT: t = clip_add(s.t, -tdb_offset(s.t), f);
      CMD_GPS_TDB: begin
        t = clip_add(s.t, OFF_TDT, f);
        t = to_tdb(t, f);
      end
      default: begin
        t = clip_add(s.t, -tdb_offset(s.t), f);
        t = clip_add(t, -OFF_TDT, f);
      end
    endcase
    r.t = t;
    r.sat = f;
    return r;
  endfunction

  function automatic longint random_time();
    longint v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = v >>> 7;               // full range scaled down by 2^7
      4, 5:       v = v >>> $urandom_range(1, 62);
      6, 7:       ;
      8:          v = MAX_T - longint'($urandom_range(0, 1 << 20)) * (1 << 12);
      default:    v = MIN_T + longint'($urandom_range(0, 1 << 20)) * (1 << 12);
    endcase
    return v;
  endfunction

  function automatic int sender_idle_pct();
    if (accepted < 450) return 32;
    if (accepted < 900) return 65;
    return 0;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIMEOUT_CYC) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Sender: a new item is offered only after the current one was taken.
  always @(negedge clk) begin
    if (rst_n && (in_taken || !in_ch.valid)) begin
      if (accepted >= PAUSE_AT && !pause_done && !pausing) pausing = 1'b1;
      if (pausing && expected_convs.size() == 0) begin
        pausing = 1'b0;
        pause_done = 1'b1;
      end
      if (pending_stamps.size() != 0 && !pausing &&
          $urandom_range(1, 100) > sender_idle_pct()) begin
        stamp_t s;
        s = pending_stamps.pop_front();
        in_ch.cmd     <= s.cmd;
        in_ch.time_in <= s.t;
        in_ch.valid   <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver, with one long stall once the first items are through.
  always @(negedge clk) begin
    if (rst_n) begin
      if (accepted >= HOLD_AT && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= $urandom_range(1, 100) > (accepted < 450 ? 65 :
                                                  accepted < 900 ? 32 : 0);
      end
    end
  end

  always @(posedge clk) begin
    in_taken = in_ch.valid && in_ch.ready;
    if (in_taken) begin
      stamp_t s;
      s.cmd = in_ch.cmd;
      s.t   = in_ch.time_in;
      expected_convs.push_back(convert(s));
      accepted = accepted + 1;
    end
    if (out_ch.valid && out_ch.ready) begin
      if (expected_convs.size() == 0) begin
        $display("%0t: unexpected item time_out %h sat %b", $time,
                 out_ch.time_out, out_ch.saturated);
        failed = 1'b1;
      end else begin
        conv_t e;
        e = expected_convs.pop_front();
        if (e.t !== out_ch.time_out || e.sat !== out_ch.saturated) begin
          $display("%0t: mismatch expected time_out %h sat %b, actual %h sat %b",
                   $time, e.t, e.sat, out_ch.time_out, out_ch.saturated);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    cmd_e c;
    stamp_t s;
    longint corner[3];
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_GPS_TDT;
    in_ch.time_in = '0;
    out_ch.ready = 1'b0;
    accepted = 0;
    cycles = 0;
    hold_left = 0;
    corner = '{0, MAX_T, MIN_T};
    c = c.first();
    do begin
      foreach (corner[k]) begin
        s.cmd = c;
        s.t = corner[k];
        pending_stamps.push_back(s);
      end
      c = c.next();
    end while (c != c.first());
    // Sums that land just on and just past the bounds.
    s.cmd = CMD_TDT_GPS; s.t = MAX_T + OFF_TDT;     pending_stamps.push_back(s);
    s.cmd = CMD_TDT_GPS; s.t = MAX_T + OFF_TDT + 1; pending_stamps.push_back(s);
    s.cmd = CMD_GPS_TAI; s.t = MIN_T - OFF_TAI;     pending_stamps.push_back(s);
    s.cmd = CMD_GPS_TAI; s.t = MIN_T - OFF_TAI - 1; pending_stamps.push_back(s);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      s.cmd = cmd_e'($urandom_range(0, 7));
      s.t = random_time();
      pending_stamps.push_back(s);
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (pending_stamps.size() == 0);
    @(posedge clk);
    wait (!in_ch.valid);
    wait (expected_convs.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (!failed && expected_convs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// File: time_scale_converter.f
rtl/tsc_pkg.sv
rtl/tsc_if.sv
rtl/tsc_cordic.sv
rtl/tsc_corr.sv
rtl/time_scale_converter.sv
tb/time_scale_converter_tb.sv
